// File: src/conv3x3_image_filter_assert.svh
// Assertion macros shared by the conv3x3_image_filter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CONV3X3_IMAGE_FILTER_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_ASSERT_SVH

// expression must hold at every clock edge outside reset
`define CIF_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CIF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/cif_pkg.sv
// Shared types and constants of the 3x3 image filter.
// No dependencies; used by the interfaces and every module of the block.
package cif_pkg;

   localparam int PIX_W          = 8;
   localparam int DIM_W          = 11;
   localparam int COEF_W         = 8;
   localparam int OUT_POS_W      = 10;
   localparam int PROD_W         = 17;
   localparam int RSUM_W         = 19;
   localparam int RES_W          = 20;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 24;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [DIM_W-1:0]      RST_FRAME_WIDTH  = DIM_W'(6);
   localparam logic [DIM_W-1:0]      RST_FRAME_HEIGHT = DIM_W'(6);
   localparam logic [CSR_DATA_W-1:0] RST_KERNEL_TOP   = 24'h050403;
   localparam logic [CSR_DATA_W-1:0] RST_KERNEL_MID   = 24'h080706;
   localparam logic [CSR_DATA_W-1:0] RST_KERNEL_BOT   = 24'h0B0A09;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MID    = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } frame_size_type;

   // kernel[row][col], left coefficient at col 0
   typedef logic [2:0][2:0][COEF_W-1:0] kernel_type;

   // window pixel at row k, column m sits at index 3*k+m
   typedef logic [8:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0] out_row;
      logic [OUT_POS_W-1:0] out_col;
      logic                 frame_last;
   } pos_type;

   typedef struct packed {
      window_type window;
      pos_type    pos;
   } work_type;

endpackage

// File: src/cif_if.sv
// Valid/ready channel interfaces of the 3x3 image filter.
// Depends on cif_pkg for field widths.
interface cif_req_if;
   logic                      valid;
   logic                      ready;
   logic [cif_pkg::PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface cif_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cif_pkg::RES_W-1:0]     filtered_value;
   logic        [cif_pkg::OUT_POS_W-1:0] out_row;
   logic        [cif_pkg::OUT_POS_W-1:0] out_col;
   logic                                 frame_last;

   modport source (output valid, output filtered_value, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input filtered_value, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

// File: src/cif_front.sv
// Front end: raster position tracking, two line stores and the 3x3 window.
// Depends on cif_pkg and cif_req_if; pushes full windows into the work queue.
module cif_front #(
   parameter int MAX_WIDTH  = cif_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cif_pkg::DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   cif_req_if.sink                 req,
   input  cif_pkg::frame_size_type size,
   input  logic                    queue_full,
   output logic                    push,
   output cif_pkg::work_type       push_data
);

   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int AX  = AW + 1;
   localparam int RX  = RW + 1;
   localparam int SWW = (CW > cif_pkg::DIM_W) ? CW : cif_pkg::DIM_W;
   localparam int SWH = (HW > cif_pkg::DIM_W) ? HW : cif_pkg::DIM_W;
   localparam int PRW = (RW > cif_pkg::OUT_POS_W) ? RW : cif_pkg::OUT_POS_W;
   localparam int PCW = (AW > cif_pkg::OUT_POS_W) ? AW : cif_pkg::OUT_POS_W;

   logic [SWW-1:0] fw_ext;
   logic [SWH-1:0] fh_ext;
   logic [CW-1:0]  w;
   logic [HW-1:0]  h;

   logic [AW-1:0]  col_ff, col_in, c;
   logic [RW-1:0]  row_ff, row_in, r;
   logic           wrap_c, col_end, row_end;
   logic [RX-1:0]  r_step, r_next;
   logic [AX-1:0]  c_next;
   logic           emit, last;
   logic [PRW-1:0] row_m1;
   logic [PCW-1:0] col_m1;

   logic                         accept, b_adv;
   logic                         b_valid_ff;
   logic                         b_emit_ff;
   logic [cif_pkg::PIX_W-1:0]    b_pixel_ff;
   logic [AW-1:0]                b_col_ff;
   cif_pkg::pos_type             b_pos_ff;
   logic [cif_pkg::PIX_W-1:0]    rd_older_ff, rd_newer_ff;
   cif_pkg::window_type          window_ff, window_in;

   logic [cif_pkg::PIX_W-1:0] older_mem [MAX_WIDTH];
   logic [cif_pkg::PIX_W-1:0] newer_mem [MAX_WIDTH];

   // frame size in use, clamped to 3..MAX
   always_comb begin
      fw_ext = SWW'(size.width);
      fh_ext = SWH'(size.height);
      if (fw_ext < SWW'(3)) begin
         w = CW'(3);
      end else if (fw_ext > SWW'(MAX_WIDTH)) begin
         w = CW'(MAX_WIDTH);
      end else begin
         w = CW'(fw_ext);
      end
      if (fh_ext < SWH'(3)) begin
         h = HW'(3);
      end else if (fh_ext > SWH'(MAX_HEIGHT)) begin
         h = HW'(MAX_HEIGHT);
      end else begin
         h = HW'(fh_ext);
      end
   end

   // position of this pixel (with resize fix-up) and of the next one
   always_comb begin
      wrap_c  = CW'(col_ff) >= w;
      c       = wrap_c ? '0 : col_ff;
      r_step  = wrap_c ? (RX'(row_ff) + RX'(1)) : RX'(row_ff);
      r       = (r_step >= RX'(h)) ? '0 : r_step[RW-1:0];
      c_next  = AX'(c) + AX'(1);
      r_next  = RX'(r) + RX'(1);
      col_end = c_next >= AX'(w);
      row_end = r_next >= RX'(h);
      col_in  = col_end ? '0 : c_next[AW-1:0];
      row_in  = col_end ? (row_end ? '0 : r_next[RW-1:0]) : r;
      emit    = (r >= RW'(2)) && (c >= AW'(2));
      last    = (r_next == RX'(h)) && (c_next == AX'(w));
      row_m1  = PRW'(r) - PRW'(1);
      col_m1  = PCW'(c) - PCW'(1);
   end

   // handshake: the staging register frees when it hands over
   assign b_adv     = b_valid_ff && (!b_emit_ff || !queue_full);
   assign req.ready = !b_valid_ff || b_adv;
   assign accept    = req.valid && req.ready;

   // window shifts one column left and takes the new column on the right
   always_comb begin
      window_in = window_ff;
      for (int k = 0; k < 3; k++) begin
         window_in[3*k]     = window_ff[3*k + 1];
         window_in[3*k + 1] = window_ff[3*k + 2];
      end
      window_in[2] = rd_older_ff;
      window_in[5] = rd_newer_ff;
      window_in[8] = b_pixel_ff;
   end

   assign push             = b_adv && b_emit_ff;
   assign push_data.window = window_in;
   assign push_data.pos    = b_pos_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         window_ff  <= '0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end
         if (b_adv) begin
            window_ff <= window_in;
         end
      end
   end

   // staging payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_pixel_ff          <= req.pixel;
         b_col_ff            <= c;
         b_emit_ff           <= emit;
         b_pos_ff.out_row    <= row_m1[cif_pkg::OUT_POS_W-1:0];
         b_pos_ff.out_col    <= col_m1[cif_pkg::OUT_POS_W-1:0];
         b_pos_ff.frame_last <= last;
      end
   end

   // line stores: read on accept, rotate the column when the item moves on
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_older_ff <= older_mem[c];
         rd_newer_ff <= newer_mem[c];
      end
      if (b_adv) begin
         older_mem[b_col_ff] <= rd_newer_ff;
         newer_mem[b_col_ff] <= b_pixel_ff;
      end
   end

endmodule

// File: src/cif_queue.sv
// Short work queue between the window front end and the multiply back end.
// Depends on cif_pkg and the assertion macro header.
`include "conv3x3_image_filter_assert.svh"

module cif_queue #(
   parameter int DEPTH = cif_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cif_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output cif_pkg::work_type pop_data,
   output logic              empty
);

   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cif_pkg::work_type slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CIF_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full, "work item pushed into full queue")
   `CIF_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, !empty, "work item popped from empty queue")
   `CIF_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue level overflow")

endmodule

// File: src/cif_back.sv
// Back end: nine parallel multiplies, row sums, total and the result register.
// Depends on cif_pkg and cif_rsp_if; takes work items from the queue.
module cif_back (
   input  logic                clock,
   input  logic                reset,
   input  cif_pkg::kernel_type kernel,
   input  cif_pkg::work_type   pop_data,
   input  logic                queue_empty,
   output logic                pop,
   cif_rsp_if.source           rsp
);

   logic en;

   logic                               s1_valid_ff;
   cif_pkg::pos_type                   s1_pos_ff;
   logic signed [cif_pkg::PROD_W-1:0]  prod_ff [9];
   logic signed [cif_pkg::PROD_W-1:0]  prod_in [9];

   logic                               s2_valid_ff;
   cif_pkg::pos_type                   s2_pos_ff;
   logic signed [cif_pkg::RSUM_W-1:0]  rsum_ff [3];
   logic signed [cif_pkg::RSUM_W-1:0]  rsum_in [3];

   logic                               out_valid_ff;
   cif_pkg::pos_type                   out_pos_ff;
   logic signed [cif_pkg::RES_W-1:0]   total_ff;
   logic signed [cif_pkg::RES_W-1:0]   total_in;

   // whole pipe moves unless the result register is held
   assign en  = !out_valid_ff || rsp.ready;
   assign pop = en && !queue_empty;

   // unsigned pixel times signed coefficient
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            prod_in[3*k + m] = cif_pkg::PROD_W'($signed({1'b0, pop_data.window[3*k + m]}))
                             * cif_pkg::PROD_W'($signed(kernel[k][m]));
         end
      end
   end

   // row sums, then the total
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rsum_in[k] = cif_pkg::RSUM_W'(prod_ff[3*k]) + cif_pkg::RSUM_W'(prod_ff[3*k + 1])
                    + cif_pkg::RSUM_W'(prod_ff[3*k + 2]);
      end
      total_in = cif_pkg::RES_W'(rsum_ff[0]) + cif_pkg::RES_W'(rsum_ff[1])
               + cif_pkg::RES_W'(rsum_ff[2]);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= !queue_empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         s1_pos_ff  <= pop_data.pos;
         rsum_ff    <= rsum_in;
         s2_pos_ff  <= s1_pos_ff;
         total_ff   <= total_in;
         out_pos_ff <= s2_pos_ff;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.filtered_value = total_ff;
   assign rsp.out_row        = out_pos_ff.out_row;
   assign rsp.out_col        = out_pos_ff.out_col;
   assign rsp.frame_last     = out_pos_ff.frame_last;

endmodule

// File: src/conv3x3_image_filter.sv
// Streaming 3x3 convolution filter, top level with the configuration registers.
// Depends on cif_pkg, cif_if, cif_front, cif_queue and cif_back.
//
// Usage:
//   req_chan carries one 8-bit pixel per item in raster order; rsp_chan carries
//   one result per interior pixel: the signed 20-bit sum of the nine
//   pixel-coefficient products, its row and column, and frame_last on the
//   final interior result of the frame. Border pixels give no result.
//   csr_we/csr_index/csr_wdata write frame width, frame height and the three
//   kernel rows; write them only while the block is idle.
//   Throughput: one pixel per clock while the work queue has room. A result
//   reaches rsp_chan through the line-store read stage, the work queue, the
//   multiply and row-sum stages and the total register, which drives rsp_chan.
//   Reset clears position, window, queue and pipeline and loads the default
//   6x6 frame and kernel; line stores are not cleared and need no sweep.
//   When the receiver stalls, the result register holds, the back end
//   freezes, the four-entry work queue fills and then req_chan.ready drops.
module conv3x3_image_filter #(
   parameter int MAX_WIDTH  = cif_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cif_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   cif_req_if.sink                          req_chan,
   cif_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [cif_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cif_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   cif_pkg::frame_size_type size_ff;
   logic [cif_pkg::CSR_DATA_W-1:0] ktop_ff, kmid_ff, kbot_ff;
   cif_pkg::kernel_type kernel;

   logic              push, pop, queue_full, queue_empty;
   cif_pkg::work_type push_data, pop_data;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff.width  <= cif_pkg::RST_FRAME_WIDTH;
         size_ff.height <= cif_pkg::RST_FRAME_HEIGHT;
         ktop_ff        <= cif_pkg::RST_KERNEL_TOP;
         kmid_ff        <= cif_pkg::RST_KERNEL_MID;
         kbot_ff        <= cif_pkg::RST_KERNEL_BOT;
      end else if (csr_we) begin
         case (cif_pkg::csr_index_type'(csr_index))
            cif_pkg::CSR_FRAME_WIDTH: begin
               size_ff.width <= csr_wdata[cif_pkg::DIM_W-1:0];
            end
            cif_pkg::CSR_FRAME_HEIGHT: begin
               size_ff.height <= csr_wdata[cif_pkg::DIM_W-1:0];
            end
            cif_pkg::CSR_KERNEL_TOP: begin
               ktop_ff <= csr_wdata;
            end
            cif_pkg::CSR_KERNEL_MID: begin
               kmid_ff <= csr_wdata;
            end
            cif_pkg::CSR_KERNEL_BOTTOM: begin
               kbot_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign kernel = {kbot_ff, kmid_ff, ktop_ff};

   cif_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .size       (size_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   cif_queue #(
      .DEPTH (cif_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   cif_back u_back (
      .clock       (clock),
      .reset       (reset),
      .kernel      (kernel),
      .pop_data    (pop_data),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule
